>>> hw/rtl/level_triggered_burst_sequencer_macros.svh
// assertion helpers used by the sequencer core
// each macro expects clk and rst_n in scope
`ifndef LEVEL_TRIGGERED_BURST_SEQUENCER_MACROS_SVH
`define LEVEL_TRIGGERED_BURST_SEQUENCER_MACROS_SVH

// condition holds at every edge out of reset
`define LBS_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LBS_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LBS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lbs_pkg.sv
package lbs_pkg;

    // default averaging window in samples
    localparam int WINDOW_DEF = 128;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_BURST_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_BURST_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_TICKS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS     = 3'd4;

    // register reset values
    localparam logic [7:0]  LEVEL_THRESHOLD_RST   = 8'd64;
    localparam logic [15:0] LONG_BURST_TICKS_RST  = 16'd5000;
    localparam logic [15:0] SHORT_BURST_TICKS_RST = 16'd2000;
    localparam logic [15:0] TAIL_TICKS_RST        = 16'd500;
    localparam logic [15:0] HOLDOFF_TICKS_RST     = 16'd5000;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BURST = 2'd1,
        PH_TAIL  = 2'd2,
        PH_HOLD  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  level_threshold;
        logic [15:0] long_burst_ticks;
        logic [15:0] short_burst_ticks;
        logic [15:0] tail_ticks;
        logic [15:0] holdoff_ticks;
    } cfg_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] sample;
        logic       manual_trigger;
        logic       inhibit;
        logic       short_select;
    } item_t;

    typedef struct packed {
        logic       led_on;
        logic       generator_on;
        logic [1:0] phase;
        logic       window_checked;
    } result_t;

endpackage

>>> hw/rtl/lbs_cfg.sv
module lbs_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lbs_pkg::cfg_t                    cfg
);

    lbs_pkg::cfg_t cfg_reg;
    lbs_pkg::cfg_t cfg_next;

    // decode of a register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lbs_pkg::REG_LEVEL_THRESHOLD:   cfg_next.level_threshold   = cfg_data[7:0];
                lbs_pkg::REG_LONG_BURST_TICKS:  cfg_next.long_burst_ticks  = cfg_data;
                lbs_pkg::REG_SHORT_BURST_TICKS: cfg_next.short_burst_ticks = cfg_data;
                lbs_pkg::REG_TAIL_TICKS:        cfg_next.tail_ticks        = cfg_data;
                lbs_pkg::REG_HOLDOFF_TICKS:     cfg_next.holdoff_ticks     = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_threshold   <= lbs_pkg::LEVEL_THRESHOLD_RST;
            cfg_reg.long_burst_ticks  <= lbs_pkg::LONG_BURST_TICKS_RST;
            cfg_reg.short_burst_ticks <= lbs_pkg::SHORT_BURST_TICKS_RST;
            cfg_reg.tail_ticks        <= lbs_pkg::TAIL_TICKS_RST;
            cfg_reg.holdoff_ticks     <= lbs_pkg::HOLDOFF_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/lbs_core.sv
`include "level_triggered_burst_sequencer_macros.svh"

module lbs_core
#(
    parameter int WINDOW = lbs_pkg::WINDOW_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lbs_pkg::item_t    item,
    input  lbs_pkg::cfg_t     cfg,
    output lbs_pkg::result_t  res
);

    localparam int SUM_W = $clog2(255 * WINDOW + 1);
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    lbs_pkg::phase_t   phase_reg;
    lbs_pkg::phase_t   phase_next;
    logic [15:0]       ticks_reg;
    logic [15:0]       ticks_next;

    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  count_acc;
    logic [SUM_W-1:0]  loud_limit;
    logic              checked;

    // running sum and count including this beat's sample when mode is low
    assign sum_acc    = item.mode ? sum_reg : sum_reg + SUM_W'(item.sample);
    assign count_acc  = item.mode ? count_reg : count_reg + CNT_W'(1);
    assign loud_limit = SUM_W'(cfg.level_threshold) * SUM_W'(WINDOW);

    // window check and burst sequencing
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        checked    = 1'b0;
        if (phase_reg == lbs_pkg::PH_IDLE)
        begin
            sum_next   = sum_acc;
            count_next = count_acc;
            if (count_acc >= CNT_W'(WINDOW) || item.manual_trigger)
            begin
                checked = 1'b1;
                if ((sum_acc > loud_limit || item.manual_trigger) && !item.inhibit)
                begin
                    phase_next = lbs_pkg::PH_BURST;
                    ticks_next = item.short_select ? cfg.short_burst_ticks
                                                   : cfg.long_burst_ticks;
                end
                sum_next   = '0;
                count_next = '0;
            end
        end
        else if (item.mode)
        begin
            if (ticks_reg > 16'd1)
            begin
                ticks_next = ticks_reg - 16'd1;
            end
            else
            begin
                case (phase_reg)
                    lbs_pkg::PH_BURST:
                    begin
                        phase_next = lbs_pkg::PH_TAIL;
                        ticks_next = cfg.tail_ticks;
                    end
                    lbs_pkg::PH_TAIL:
                    begin
                        phase_next = lbs_pkg::PH_HOLD;
                        ticks_next = cfg.holdoff_ticks;
                    end
                    default:
                    begin
                        phase_next = lbs_pkg::PH_IDLE;
                        ticks_next = '0;
                    end
                endcase
            end
        end
    end

    // state registers, advanced once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            phase_reg <= lbs_pkg::PH_IDLE;
            ticks_reg <= '0;
        end
        else if (step)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
        end
    end

    // result describes the state after this beat
    always_comb
    begin
        res.led_on         = (phase_next == lbs_pkg::PH_BURST) ||
                             (phase_next == lbs_pkg::PH_TAIL);
        res.generator_on   = (phase_next == lbs_pkg::PH_BURST);
        res.phase          = phase_next;
        res.window_checked = checked;
    end

    `LBS_ASSERT_IMPLIES(a_quiet_when_busy, phase_reg != lbs_pkg::PH_IDLE, sum_reg == '0 && count_reg == '0, "sum or count not clear during a sequence")
    `LBS_ASSERT_ALWAYS(a_count_below_window, count_reg < CNT_W'(WINDOW), "sample count reached a full window without a check")
    `LBS_ASSERT_IMPLIES(a_start_needs_check, step && phase_reg == lbs_pkg::PH_IDLE && phase_next != lbs_pkg::PH_IDLE, checked, "sequence started without a check")
    `LBS_ASSERT_NEXT(a_burst_entry, step && phase_reg == lbs_pkg::PH_IDLE && phase_next == lbs_pkg::PH_BURST, phase_reg == lbs_pkg::PH_BURST, "burst phase not entered after a start")

endmodule

>>> hw/rtl/level_triggered_burst_sequencer.sv
// a beat waits in the input register until the output slot frees, then its result is registered
// throughput: one beat per cycle if out_stall is low; state and result take one registered pass
// input stall rises only when both the input and output registers hold beats and out_stall is high
// reset (rst_n, asynchronous, active low): configuration registers take their default values,
// sum and count clear, phase idle, both pipeline registers empty
module level_triggered_burst_sequencer
#(
    parameter int WINDOW = lbs_pkg::WINDOW_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [7:0]                      sample,
    input  logic                            manual_trigger,
    input  logic                            inhibit,
    input  logic                            short_select,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            led_on,
    output logic                            generator_on,
    output logic [1:0]                      phase,
    output logic                            window_checked
);

    lbs_pkg::cfg_t     cfg;
    lbs_pkg::item_t    item_reg;
    logic              in_valid_reg;
    lbs_pkg::result_t  res;
    lbs_pkg::result_t  res_reg;
    logic              out_valid_reg;
    logic              advance;

    // beat moves from input to output register when the output slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    lbs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.mode           <= mode;
            item_reg.sample         <= sample;
            item_reg.manual_trigger <= manual_trigger;
            item_reg.inhibit        <= inhibit;
            item_reg.short_select   <= short_select;
        end
    end

    lbs_core #(
        .WINDOW (WINDOW)
    ) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_on         = res_reg.led_on;
    assign generator_on   = res_reg.generator_on;
    assign phase          = res_reg.phase;
    assign window_checked = res_reg.window_checked;

endmodule

>>> sim/tb_level_triggered_burst_sequencer.sv
module tb_level_triggered_burst_sequencer;

    localparam int WINDOW      = lbs_pkg::WINDOW_DEF;
    localparam int QUIET_LIMIT = 5000;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    // how the samples of one window are shaped
    typedef enum int {
        WIN_AT_LEVEL,
        WIN_JUST_OVER,
        WIN_SPREAD,
        WIN_FULL_SCALE,
        WIN_SILENT
    } window_style_t;

    typedef struct packed {
        row_kind_t                          kind;
        lbs_pkg::item_t                     stim;
        logic                               typed;
        lbs_pkg::result_t                   want;
        logic [lbs_pkg::CFG_IDX_W-1:0]      idx;
        logic [lbs_pkg::CFG_DATA_W-1:0]     data;
    } plan_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [lbs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lbs_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           mode;
    logic [7:0]                     sample;
    logic                           manual_trigger;
    logic                           inhibit;
    logic                           short_select;
    logic                           out_valid;
    logic                           out_stall;
    logic                           led_on;
    logic                           generator_on;
    logic [1:0]                     phase;
    logic                           window_checked;

    // shadow of the registers and the sequencer state
    lbs_pkg::cfg_t      regs_shadow;
    int                 acc_sum;
    int                 acc_count;
    int                 ticks_rem;
    lbs_pkg::phase_t    seq_ph;

    lbs_pkg::result_t   pending_results[$];
    plan_row_t          plan[$];
    window_style_t      win_style;
    int                 mismatches;
    int                 quiet_cycles;
    bit                 calm;

    level_triggered_burst_sequencer #(.WINDOW(WINDOW)) u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .sample         (sample),
        .manual_trigger (manual_trigger),
        .inhibit        (inhibit),
        .short_select   (short_select),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .led_on         (led_on),
        .generator_on   (generator_on),
        .phase          (phase),
        .window_checked (window_checked)
    );

    always #2 clk = ~clk;

    // next state and outputs of the sequencer for one beat
    task automatic predict_item(input lbs_pkg::item_t b, output lbs_pkg::result_t r);
        logic checked;
        logic loud;
        checked = 1'b0;
        if (seq_ph == lbs_pkg::PH_IDLE)
        begin
            if (!b.mode)
            begin
                acc_sum   = acc_sum + int'(b.sample);
                acc_count = acc_count + 1;
            end
            if (acc_count >= WINDOW || b.manual_trigger)
            begin
                loud    = acc_sum > int'(regs_shadow.level_threshold) * WINDOW;
                checked = 1'b1;
                if ((loud || b.manual_trigger) && !b.inhibit)
                begin
                    seq_ph    = lbs_pkg::PH_BURST;
                    ticks_rem = b.short_select ? int'(regs_shadow.short_burst_ticks)
                                               : int'(regs_shadow.long_burst_ticks);
                end
                acc_sum   = 0;
                acc_count = 0;
            end
        end
        else if (b.mode)
        begin
            if (ticks_rem > 1)
                ticks_rem = ticks_rem - 1;
            else if (seq_ph == lbs_pkg::PH_BURST)
            begin
                seq_ph    = lbs_pkg::PH_TAIL;
                ticks_rem = int'(regs_shadow.tail_ticks);
            end
            else if (seq_ph == lbs_pkg::PH_TAIL)
            begin
                seq_ph    = lbs_pkg::PH_HOLD;
                ticks_rem = int'(regs_shadow.holdoff_ticks);
            end
            else
            begin
                seq_ph    = lbs_pkg::PH_IDLE;
                ticks_rem = 0;
            end
        end
        r.led_on         = (seq_ph == lbs_pkg::PH_BURST) || (seq_ph == lbs_pkg::PH_TAIL);
        r.generator_on   = (seq_ph == lbs_pkg::PH_BURST);
        r.phase          = seq_ph;
        r.window_checked = checked;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lbs_pkg::REG_LEVEL_THRESHOLD:   regs_shadow.level_threshold   = data[7:0];
            lbs_pkg::REG_LONG_BURST_TICKS:  regs_shadow.long_burst_ticks  = data;
            lbs_pkg::REG_SHORT_BURST_TICKS: regs_shadow.short_burst_ticks = data;
            lbs_pkg::REG_TAIL_TICKS:        regs_shadow.tail_ticks        = data;
            lbs_pkg::REG_HOLDOFF_TICKS:     regs_shadow.holdoff_ticks     = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input lbs_pkg::cfg_t c);
        write_reg(lbs_pkg::REG_LEVEL_THRESHOLD, {8'h00, c.level_threshold});
        write_reg(lbs_pkg::REG_LONG_BURST_TICKS, c.long_burst_ticks);
        write_reg(lbs_pkg::REG_SHORT_BURST_TICKS, c.short_burst_ticks);
        write_reg(lbs_pkg::REG_TAIL_TICKS, c.tail_ticks);
        write_reg(lbs_pkg::REG_HOLDOFF_TICKS, c.holdoff_ticks);
    endtask

    // queue the expectation, then offer the beat until it is taken
    task automatic send_beat(input lbs_pkg::item_t b, input logic typed,
                             input lbs_pkg::result_t want);
        lbs_pkg::result_t r;
        predict_item(b, r);
        pending_results.push_back(typed ? want : r);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= b.mode;
        sample         <= b.sample;
        manual_trigger <= b.manual_trigger;
        inhibit        <= b.inhibit;
        short_select   <= b.short_select;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // mostly well-formed windows and tick runs, with some noise
    task automatic make_beat(input int manual_pct, output lbs_pkg::item_t b);
        logic [7:0] thr;
        thr              = regs_shadow.level_threshold;
        b.sample         = 8'($urandom_range(0, 255));
        b.inhibit        = ($urandom_range(0, 3) == 0);
        b.short_select   = 1'($urandom_range(0, 1));
        b.manual_trigger = 1'b0;
        if (seq_ph == lbs_pkg::PH_IDLE)
        begin
            if (acc_count == 0)
                win_style = window_style_t'($urandom_range(0, 4));
            b.mode           = ($urandom_range(0, 9) == 0);
            b.manual_trigger = ($urandom_range(0, 99) < manual_pct);
            case (win_style)
                WIN_AT_LEVEL:   b.sample = thr;
                WIN_JUST_OVER:  b.sample = (acc_count == 0 && thr != 8'hFF) ? thr + 8'd1 : thr;
                WIN_FULL_SCALE: b.sample = 8'hFF;
                WIN_SILENT:     b.sample = 8'h00;
                default: ;
            endcase
        end
        else
        begin
            b.mode           = ($urandom_range(0, 4) != 0);
            b.manual_trigger = 1'($urandom_range(0, 1));
        end
        // occasional stray beat
        if ($urandom_range(0, 19) == 0)
        begin
            b.mode           = 1'($urandom_range(0, 1));
            b.manual_trigger = 1'($urandom_range(0, 1));
        end
    endtask

    // every beat sent counts, ignored samples included
    task automatic run_random(input int n_items, input int pause_at, input int manual_pct);
        int             done;
        lbs_pkg::item_t b;
        done = 0;
        while (done < n_items)
        begin
            make_beat(manual_pct, b);
            send_beat(b, 1'b0, '0);
            done = done + 1;
            if (done == pause_at)
                drain_results();
        end
    endtask

    function automatic plan_row_t beat_row(input logic md, input logic [7:0] smp,
                                           input logic man, input logic inh, input logic sh,
                                           input logic typed, input lbs_pkg::result_t want);
        plan_row_t row;
        row                     = '0;
        row.kind                = ROW_BEAT;
        row.stim.mode           = md;
        row.stim.sample         = smp;
        row.stim.manual_trigger = man;
        row.stim.inhibit        = inh;
        row.stim.short_select   = sh;
        row.typed               = typed;
        row.want                = want;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [lbs_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [15:0] data);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // random stall on the result side
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 16);

    // result checker
    always @(posedge clk)
    begin
        lbs_pkg::result_t got;
        lbs_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {led_on, generator_on, phase, window_checked};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %b", $time, got);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.led_on !== want.led_on)
                begin
                    $display("%0t: led_on expected %0b actual %0b",
                             $time, want.led_on, got.led_on);
                    mismatches = mismatches + 1;
                end
                if (got.generator_on !== want.generator_on)
                begin
                    $display("%0t: generator_on expected %0b actual %0b",
                             $time, want.generator_on, got.generator_on);
                    mismatches = mismatches + 1;
                end
                if (got.phase !== want.phase)
                begin
                    $display("%0t: phase expected %0d actual %0d",
                             $time, want.phase, got.phase);
                    mismatches = mismatches + 1;
                end
                if (got.window_checked !== want.window_checked)
                begin
                    $display("%0t: window_checked expected %0b actual %0b",
                             $time, want.window_checked, got.window_checked);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // cycles without any beat moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        lbs_pkg::cfg_t mix;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = lbs_pkg::REG_LEVEL_THRESHOLD;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = 1'b0;
        sample         = '0;
        manual_trigger = 1'b0;
        inhibit        = 1'b0;
        short_select   = 1'b0;
        out_stall      = 1'b0;
        calm           = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        win_style      = WIN_SPREAD;
        regs_shadow.level_threshold   = lbs_pkg::LEVEL_THRESHOLD_RST;
        regs_shadow.long_burst_ticks  = lbs_pkg::LONG_BURST_TICKS_RST;
        regs_shadow.short_burst_ticks = lbs_pkg::SHORT_BURST_TICKS_RST;
        regs_shadow.tail_ticks        = lbs_pkg::TAIL_TICKS_RST;
        regs_shadow.holdoff_ticks     = lbs_pkg::HOLDOFF_TICKS_RST;
        acc_sum   = 0;
        acc_count = 0;
        ticks_rem = 0;
        seq_ph    = lbs_pkg::PH_IDLE;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: reset settings first, then short phases
        // tick while idle, sample ignored
        plan.push_back(beat_row(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b0}));
        plan.push_back(beat_row(1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b0}));
        plan.push_back(beat_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b0}));
        // manual check held back by inhibit, on a sample and on a tick
        plan.push_back(beat_row(1'b0, 8'hAA, 1'b1, 1'b1, 1'b0, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b1}));
        plan.push_back(beat_row(1'b1, 8'h55, 1'b1, 1'b1, 1'b1, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b1}));
        plan.push_back(reg_row(lbs_pkg::REG_LONG_BURST_TICKS, 16'd2));
        plan.push_back(reg_row(lbs_pkg::REG_SHORT_BURST_TICKS, 16'd0));
        plan.push_back(reg_row(lbs_pkg::REG_TAIL_TICKS, 16'd1));
        plan.push_back(reg_row(lbs_pkg::REG_HOLDOFF_TICKS, 16'd1));
        // manual start with the short burst length set to zero
        plan.push_back(beat_row(1'b0, 8'h03, 1'b1, 1'b0, 1'b1, 1'b1,
                                {1'b1, 1'b1, lbs_pkg::PH_BURST, 1'b1}));
        // sample, manual and inhibit ignored mid-sequence
        plan.push_back(beat_row(1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(beat_row(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                                {1'b1, 1'b0, lbs_pkg::PH_TAIL, 1'b0}));
        plan.push_back(beat_row(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_HOLD, 1'b0}));
        plan.push_back(beat_row(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b0}));
        // start on a tick: that tick does not count towards the burst
        plan.push_back(beat_row(1'b1, 8'h80, 1'b1, 1'b0, 1'b0, 1'b1,
                                {1'b1, 1'b1, lbs_pkg::PH_BURST, 1'b1}));
        plan.push_back(beat_row(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(beat_row(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
                                {1'b1, 1'b0, lbs_pkg::PH_TAIL, 1'b0}));
        plan.push_back(beat_row(1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(beat_row(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b0}));
        plan.push_back(beat_row(1'b0, 8'h7F, 1'b1, 1'b1, 1'b1, 1'b1,
                                {1'b0, 1'b0, lbs_pkg::PH_IDLE, 1'b1}));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_beat(plan[i].stim, plan[i].typed, plan[i].want);
        end

        // zero threshold, short phases, with a full pause mid-way
        mix.level_threshold   = 8'd0;
        mix.long_burst_ticks  = 16'd3;
        mix.short_burst_ticks = 16'd1;
        mix.tail_ticks        = 16'd2;
        mix.holdoff_ticks     = 16'd4;
        load_settings(mix);
        run_random(400, 200, 1);

        // top threshold, every phase loaded with zero
        mix.level_threshold   = 8'd255;
        mix.long_burst_ticks  = 16'd0;
        mix.short_burst_ticks = 16'd0;
        mix.tail_ticks        = 16'd0;
        mix.holdoff_ticks     = 16'd0;
        load_settings(mix);
        run_random(350, 0, 4);

        // random mid-range settings, first stretch without any idling
        mix.level_threshold   = 8'($urandom_range(40, 200));
        mix.long_burst_ticks  = 16'($urandom_range(0, 24));
        mix.short_burst_ticks = 16'($urandom_range(0, 24));
        mix.tail_ticks        = 16'($urandom_range(0, 24));
        mix.holdoff_ticks     = 16'($urandom_range(0, 24));
        load_settings(mix);
        calm = 1'b1;
        run_random(200, 0, 1);
        calm = 1'b0;
        run_random(150, 0, 1);

        // largest tick counts; the sequence never finishes here
        mix.level_threshold   = 8'd1;
        mix.long_burst_ticks  = 16'hFFFF;
        mix.short_burst_ticks = 16'hFFFF;
        mix.tail_ticks        = 16'hFFFF;
        mix.holdoff_ticks     = 16'hFFFF;
        load_settings(mix);
        run_random(200, 0, 1);

        drain_results();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
